>>> src/length_prefixed_frame_extractor_core_macros.svh
// assertion helpers used by the checker file
`ifndef LENGTH_PREFIXED_FRAME_EXTRACTOR_CORE_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_EXTRACTOR_CORE_MACROS_SVH

// clocked assertion with no reset qualifier
`define LPFE_ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// clocked assertion that is off while the active-low reset is held
`define LPFE_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> src/lpfe_pkg.sv
`timescale 1ns / 1ps
package lpfe_pkg;

    // frame layout
    localparam int HEADER_BYTES = 32;
    localparam int LEN_OFFSET   = 4;
    localparam int LEN_BYTES    = 4;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);

    // field widths
    localparam int DATA_W  = 8;
    localparam int LEN_W   = 32;
    localparam int LIMIT_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

    // decoupling queue between the front and back parts
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // kind of work handed from the front to the back
    typedef enum logic [1:0] {
        QK_STORE   = 2'd0,
        QK_HDR_END = 2'd1,
        QK_PASS    = 2'd2
    } t_qkind;

    typedef struct packed {
        t_qkind                kind;
        logic [DATA_W-1:0]     data;
        logic [HDR_IDX_W-1:0]  idx;
        logic                  last;    // pass: final byte; header end: empty payload
        logic                  accept;  // header end: frame kept
    } t_qentry;

    typedef enum logic {
        BK_STREAM = 1'b0,
        BK_REPLAY = 1'b1
    } t_back_state;

endpackage

>>> src/lpfe_in_if.sv
`timescale 1ns / 1ps
interface lpfe_in_if;
    import lpfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

>>> src/lpfe_out_if.sv
`timescale 1ns / 1ps
interface lpfe_out_if;
    import lpfe_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] out_byte;
    logic              first_of_frame;
    logic              last_of_frame;

    modport source (output valid, output out_byte, output first_of_frame,
                    output last_of_frame, input ready);
    modport sink   (input valid, input out_byte, input first_of_frame,
                    input last_of_frame, output ready);
endinterface

>>> src/lpfe_front.sv
`timescale 1ns / 1ps
module lpfe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpfe_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    lpfe_in_if.sink                       i_in,
    output logic                          o_push_valid,
    output lpfe_pkg::t_qentry             o_push_entry,
    input  logic                          i_push_ready
);
    import lpfe_pkg::*;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

    logic [LIMIT_W-1:0]   r_frame_limit;
    logic [HDR_IDX_W-1:0] r_hdr_count, n_hdr_count;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [LEN_W-1:0]     r_left, n_left;
    logic                 r_in_payload, n_in_payload;

    logic                 w_take;
    logic                 w_hdr_end;
    logic [LEN_W:0]       w_total;
    logic                 w_keep;
    logic                 w_zero_len;

    assign i_in.ready   = i_push_ready;
    assign w_take       = i_in.valid & i_push_ready;
    assign o_push_valid = i_in.valid;
    assign w_hdr_end    = (r_hdr_count == HDR_LAST);

    // length word, with the incoming byte overlaid when it is a length byte
    always_comb begin
        n_len = r_len;
        for (int k = 0; k < LEN_BYTES; k++) begin
            if (!r_in_payload && r_hdr_count == HDR_IDX_W'(LEN_OFFSET + k)) begin
                n_len[DATA_W*k +: DATA_W] = i_in.data_byte;
            end
        end
    end

    // size check without wrap-around
    assign w_total    = {1'b0, n_len} + (LEN_W + 1)'(HEADER_BYTES);
    assign w_keep     = (w_total < {{(LEN_W + 1 - LIMIT_W){1'b0}}, r_frame_limit});
    assign w_zero_len = (n_len == '0);

    // classify the byte
    always_comb begin
        o_push_entry.data   = i_in.data_byte;
        o_push_entry.idx    = r_hdr_count;
        o_push_entry.accept = 1'b0;
        o_push_entry.last   = 1'b0;
        o_push_entry.kind   = QK_STORE;
        n_hdr_count  = r_hdr_count;
        n_left       = r_left;
        n_in_payload = r_in_payload;
        if (r_in_payload) begin
            o_push_entry.kind = QK_PASS;
            o_push_entry.last = (r_left <= LEN_W'(1));
            n_left            = r_left - LEN_W'(1);
            if (r_left <= LEN_W'(1)) begin
                n_in_payload = 1'b0;
            end
        end else if (w_hdr_end) begin
            o_push_entry.kind   = QK_HDR_END;
            o_push_entry.accept = w_keep;
            o_push_entry.last   = w_zero_len;
            n_hdr_count         = '0;
            if (w_keep && !w_zero_len) begin
                n_in_payload = 1'b1;
                n_left       = n_len;
            end
        end else begin
            n_hdr_count = r_hdr_count + HDR_IDX_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_count  <= '0;
            r_in_payload <= 1'b0;
            r_left       <= '0;
        end else if (w_take) begin
            r_hdr_count  <= n_hdr_count;
            r_in_payload <= n_in_payload;
            r_left       <= n_left;
        end
    end

    // length capture
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_len <= n_len;
        end
    end

    // size limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_frame_limit <= i_cfg_wdata;
        end
    end
endmodule

>>> src/lpfe_queue.sv
`timescale 1ns / 1ps
module lpfe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  lpfe_pkg::t_qentry i_push_entry,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output lpfe_pkg::t_qentry o_pop_entry,
    input  logic              i_pop
);
    import lpfe_pkg::*;

    t_qentry              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr;
    logic [Q_PTR_W-1:0]   r_rd;
    logic [Q_CNT_W-1:0]   r_cnt;
    logic                 w_push;
    logic                 w_pop;

    assign o_push_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign w_push       = i_push_valid & o_push_ready;
    assign w_pop        = i_pop & o_pop_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + Q_CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - Q_CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end
endmodule

>>> src/lpfe_back.sv
`timescale 1ns / 1ps
module lpfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  lpfe_pkg::t_qentry i_q_entry,
    output logic              o_q_pop,
    lpfe_out_if.source        o_out
);
    import lpfe_pkg::*;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

    t_back_state          r_state, n_state;
    logic [DATA_W-1:0]    r_hdr_store [HEADER_BYTES];
    logic [HDR_IDX_W-1:0] r_idx;
    logic                 r_zero_len;

    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_byte;
    logic                 r_out_first;
    logic                 r_out_last;

    logic                 w_can_load;
    logic                 w_load;
    logic                 w_load_first;
    logic                 w_load_last;
    logic                 w_store_we;
    logic                 w_start_replay;

    assign w_can_load = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_STREAM: begin
                if (i_q_valid && i_q_entry.kind == QK_HDR_END && i_q_entry.accept) begin
                    n_state = BK_REPLAY;
                end
            end
            BK_REPLAY: begin
                if (w_can_load && r_idx == HDR_LAST) begin
                    n_state = BK_STREAM;
                end
            end
            default: n_state = BK_STREAM;
        endcase
    end

    // queue pops, store writes and output loads
    always_comb begin
        o_q_pop        = 1'b0;
        w_store_we     = 1'b0;
        w_start_replay = 1'b0;
        w_load         = 1'b0;
        w_load_first   = 1'b0;
        w_load_last    = i_q_entry.last;
        case (r_state)
            BK_STREAM: begin
                if (i_q_valid) begin
                    case (i_q_entry.kind)
                        QK_STORE: begin
                            o_q_pop    = 1'b1;
                            w_store_we = 1'b1;
                        end
                        QK_HDR_END: begin
                            o_q_pop        = 1'b1;
                            w_store_we     = 1'b1;
                            w_start_replay = i_q_entry.accept;
                        end
                        QK_PASS: begin
                            o_q_pop = w_can_load;
                            w_load  = w_can_load;
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            BK_REPLAY: begin
                w_load       = w_can_load;
                w_load_first = (r_idx == '0);
                w_load_last  = (r_idx == HDR_LAST) && r_zero_len;
            end
            default: ;
        endcase
    end

    // state and replay index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_STREAM;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (w_start_replay) begin
                r_idx <= '0;
            end else if (r_state == BK_REPLAY && w_can_load) begin
                r_idx <= r_idx + HDR_IDX_W'(1);
            end
        end
    end

    // empty-payload flag of the frame being replayed
    always_ff @(posedge i_clk) begin
        if (w_start_replay) begin
            r_zero_len <= i_q_entry.last;
        end
    end

    // header store
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_hdr_store[i_q_entry.idx] <= i_q_entry.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // replay bytes are read from the header store straight into the output
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_state == BK_REPLAY) begin
                r_out_byte <= r_hdr_store[r_idx];
            end else begin
                r_out_byte <= i_q_entry.data;
            end
            r_out_first <= w_load_first;
            r_out_last  <= w_load_last;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.first_of_frame = r_out_first;
    assign o_out.last_of_frame  = r_out_last;
endmodule

>>> src/length_prefixed_frame_extractor_core.sv
`timescale 1ns / 1ps
// channel   | dir | handshake       | payload
// i_in      | in  | valid / ready   | data_byte[7:0]
// o_out     | out | valid / ready   | out_byte[7:0], first_of_frame, last_of_frame
// cfg       | in  | i_cfg_we        | i_cfg_wdata[15:0] (frame_limit)
//
// one input byte per cycle while the 4-entry queue has room; payload bytes
// leave one per cycle while the output is ready, each shown in the cycle after the back part pops it
// a kept header replays from the header store at one byte per cycle while the
// output is ready; input stalls during the replay once the queue fills,
// longer while the output is stalled
// i_rst_n is synchronous; the header store is not cleared and needs no sweep
// either side may stall on its own; the output register holds a result
// while new bytes are still taken into the queue
module length_prefixed_frame_extractor_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpfe_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    lpfe_in_if.sink                       i_in,
    lpfe_out_if.source                    o_out
);
    import lpfe_pkg::*;

    logic    w_push_valid;
    logic    w_push_ready;
    t_qentry w_push_entry;
    logic    w_pop_valid;
    t_qentry w_pop_entry;
    logic    w_pop;

    // byte classification and size check
    lpfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_entry (w_push_entry),
        .i_push_ready (w_push_ready)
    );

    // decoupling queue
    lpfe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_entry (w_push_entry),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_entry  (w_pop_entry),
        .i_pop        (w_pop)
    );

    // header store, replay and output
    lpfe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_pop_valid),
        .i_q_entry (w_pop_entry),
        .o_q_pop   (w_pop),
        .o_out     (o_out)
    );
endmodule

>>> src/lpfe_checker.sv
`timescale 1ns / 1ps
`include "length_prefixed_frame_extractor_core_macros.svh"
module lpfe_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lpfe_pkg::DATA_W-1:0]  i_out_byte,
    input logic                         i_out_first,
    input logic                         i_out_last
);
    // a stalled request keeps its contents
    `LPFE_ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_first) && $stable(i_out_last),
        "output request changed while stalled")

    // header replay runs on without a gap and never closes at its first byte
    `LPFE_ASSERT_RST(a_replay_flow, i_clk, i_rst_n,
        i_out_valid && i_out_ready && i_out_first
            |=> i_out_valid && !i_out_first && !i_out_last,
        "header replay broke after its first byte")

    // reset empties the output register
    `LPFE_ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid,
        "output valid after reset")
endmodule

bind length_prefixed_frame_extractor_core lpfe_checker u_lpfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_first (o_out.first_of_frame),
    .i_out_last  (o_out.last_of_frame)
);
